FILE: rtl/signed_restoring_divider_assert.svh
// assertion macros for the signed restoring divider
`ifndef SIGNED_RESTORING_DIVIDER_ASSERT_SVH
`define SIGNED_RESTORING_DIVIDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRD_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("srd assertion failed");

// next-cycle implication, checked out of reset
`define SRD_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("srd assertion failed");

`endif

FILE: rtl/srd_pkg.sv
// types and constants shared by the signed restoring divider
package srd_pkg;

    localparam int FIELD_W       = 16;
    localparam int WIDTH_DEFAULT = 16;

    localparam logic [FIELD_W:0] FIELD_SPAN = {1'b1, {FIELD_W{1'b0}}};

    typedef logic signed [FIELD_W-1:0] field_t;

    typedef struct packed {
        logic neg_rem;
        logic neg_quo;
        logic zero_div;
    } flags_t;

endpackage

FILE: rtl/signed_restoring_divider.sv
// signed restoring divider, one quotient bit retired per pipeline stage
// pipeline of one operand stage, WIDTH subtract-and-restore stages and one sign-fix output stage
// one item per cycle while the result is not stalled; a stalled result is held while empty stages still fill
// reset: asynchronous active-low rst_n clears every stage valid bit and the result valid
`include "signed_restoring_divider_assert.svh"

module signed_restoring_divider #(
    parameter int WIDTH = srd_pkg::WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           operand_valid,
    output logic           operand_stall,
    input  srd_pkg::field_t dividend,
    input  srd_pkg::field_t divisor,
    output logic           result_valid,
    input  logic           result_stall,
    output srd_pkg::field_t quotient,
    output srd_pkg::field_t remainder,
    output logic           divide_by_zero
);
    import srd_pkg::*;

    logic                 neg_dd;
    logic                 neg_dv;
    logic [FIELD_W:0]     mag_dd;
    logic [FIELD_W:0]     mag_dv;
    logic [WIDTH+FIELD_W:0] ext_dd;
    logic [WIDTH+FIELD_W:0] ext_dv;

    logic [WIDTH-1:0] a_reg    [0:WIDTH];
    logic [WIDTH-1:0] q_reg    [0:WIDTH];
    logic [WIDTH-1:0] m_reg    [0:WIDTH];
    flags_t           flag_reg [0:WIDTH];
    logic             valid_reg [0:WIDTH];

    logic [WIDTH-1:0] a_next    [0:WIDTH];
    logic [WIDTH-1:0] q_next    [0:WIDTH];
    logic [WIDTH-1:0] m_next    [0:WIDTH];
    flags_t           flag_next [0:WIDTH];
    logic             valid_next [0:WIDTH];
    logic             feed      [0:WIDTH];
    logic             open      [0:WIDTH];

    logic             out_open;
    logic             result_valid_reg;
    field_t           quotient_reg;
    field_t           remainder_reg;
    logic             dz_reg;

    logic [WIDTH-1:0]         rem_w;
    logic [WIDTH-1:0]         quo_w;
    logic [WIDTH+FIELD_W-1:0] rem_ext;
    logic [WIDTH+FIELD_W-1:0] quo_ext;
    field_t                   quotient_next;
    field_t                   remainder_next;

    // operand stage: magnitudes cut to the datapath width
    assign neg_dd = dividend[FIELD_W-1];
    assign neg_dv = divisor[FIELD_W-1];
    assign mag_dd = neg_dd ? (FIELD_SPAN - {1'b0, dividend}) : {1'b0, dividend};
    assign mag_dv = neg_dv ? (FIELD_SPAN - {1'b0, divisor}) : {1'b0, divisor};
    assign ext_dd = {{WIDTH{1'b0}}, mag_dd};
    assign ext_dv = {{WIDTH{1'b0}}, mag_dv};

    assign feed[0]               = operand_valid;
    assign a_next[0]             = '0;
    assign q_next[0]             = ext_dd[WIDTH-1:0];
    assign m_next[0]             = ext_dv[WIDTH-1:0];
    assign flag_next[0].neg_rem  = neg_dd;
    assign flag_next[0].neg_quo  = (dividend != '0) && (neg_dd != neg_dv);
    assign flag_next[0].zero_div = (divisor == '0);

    // one shift, subtract and restore per stage
    for (genvar k = 1; k <= WIDTH; k++) begin : g_step
        logic [WIDTH-1:0] a_sh;
        logic [WIDTH-1:0] diff;

        assign a_sh         = {a_reg[k-1][WIDTH-2:0], q_reg[k-1][WIDTH-1]};
        assign diff         = a_sh - m_reg[k-1];
        assign feed[k]      = valid_reg[k-1];
        assign a_next[k]    = diff[WIDTH-1] ? a_sh : diff;
        assign q_next[k]    = {q_reg[k-1][WIDTH-2:0], ~diff[WIDTH-1]};
        assign m_next[k]    = m_reg[k-1];
        assign flag_next[k] = flag_reg[k-1];
    end

    // a stage takes a new item when it is empty or its item moves on
    assign out_open    = !result_valid_reg || !result_stall;
    assign open[WIDTH] = !valid_reg[WIDTH] || out_open;
    for (genvar k = 0; k < WIDTH; k++) begin : g_open
        assign open[k] = !valid_reg[k] || open[k+1];
    end

    for (genvar k = 0; k <= WIDTH; k++) begin : g_stage
        assign valid_next[k] = open[k] ? feed[k] : valid_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (open[k] && feed[k])
            begin
                a_reg[k]    <= a_next[k];
                q_reg[k]    <= q_next[k];
                m_reg[k]    <= m_next[k];
                flag_reg[k] <= flag_next[k];
            end
        end
    end

    // output stage: signs restored, sign-extended or cut to the field width
    assign rem_w   = flag_reg[WIDTH].neg_rem ? (WIDTH'(0) - a_reg[WIDTH]) : a_reg[WIDTH];
    assign quo_w   = flag_reg[WIDTH].neg_quo ? (WIDTH'(0) - q_reg[WIDTH]) : q_reg[WIDTH];
    assign rem_ext = {{FIELD_W{rem_w[WIDTH-1]}}, rem_w};
    assign quo_ext = {{FIELD_W{quo_w[WIDTH-1]}}, quo_w};

    assign quotient_next  = flag_reg[WIDTH].zero_div ? '0 : field_t'(quo_ext[FIELD_W-1:0]);
    assign remainder_next = flag_reg[WIDTH].zero_div ? '0 : field_t'(rem_ext[FIELD_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            result_valid_reg <= valid_reg[WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_open && valid_reg[WIDTH])
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
            dz_reg        <= flag_reg[WIDTH].zero_div;
        end
    end

    assign operand_stall  = !open[0];
    assign result_valid   = result_valid_reg;
    assign quotient       = quotient_reg;
    assign remainder      = remainder_reg;
    assign divide_by_zero = dz_reg;

    `SRD_ASSERT_NOW(a_dz_zero, result_valid && divide_by_zero, quotient == '0 && remainder == '0)
    `SRD_ASSERT_NOW(a_stall_full, operand_stall, valid_reg[0] && valid_reg[WIDTH])
    `SRD_ASSERT_NEXT(a_last_moves, out_open && valid_reg[WIDTH], result_valid)
    `SRD_ASSERT_NEXT(a_drain, result_valid && !result_stall && !valid_reg[WIDTH], !result_valid)

endmodule

FILE: tb/srd_checker.sv
// checker for the signed restoring divider: predicts each quotient and remainder and compares
module srd_checker #(
    parameter int WIDTH = srd_pkg::WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            operand_valid,
    input  logic            operand_stall,
    input  srd_pkg::field_t dividend,
    input  srd_pkg::field_t divisor,
    input  logic            result_valid,
    input  logic            result_stall,
    input  srd_pkg::field_t quotient,
    input  srd_pkg::field_t remainder,
    input  logic            divide_by_zero,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import srd_pkg::*;

    typedef struct packed {
        field_t quo;
        field_t rem;
        logic   dz;
    } division_t;

    division_t pending_divisions[$];
    division_t want;

    function automatic division_t restoring_divide(field_t dd, field_t dv);
        division_t        r;
        logic [FIELD_W:0] dd_mag;
        logic [FIELD_W:0] dv_mag;
        logic [WIDTH-1:0] acc;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] div;
        logic [WIDTH-1:0] diff;
        logic             dd_neg;
        logic             dv_neg;
        dd_neg = dd[FIELD_W-1];
        dv_neg = dv[FIELD_W-1];
        dd_mag = dd_neg ? FIELD_SPAN - {1'b0, dd} : {1'b0, dd};
        dv_mag = dv_neg ? FIELD_SPAN - {1'b0, dv} : {1'b0, dv};
        r.dz = (dv == '0);
        if (r.dz)
        begin
            r.quo = '0;
            r.rem = '0;
            return r;
        end
        acc = '0;
        quo = WIDTH'(dd_mag);
        div = WIDTH'(dv_mag);
        for (int s = 0; s < WIDTH; s++)
        begin
            acc  = {acc[WIDTH-2:0], quo[WIDTH-1]};
            quo  = quo << 1;
            diff = acc - div;
            if (!diff[WIDTH-1])
            begin
                acc    = diff;
                quo[0] = 1'b1;
            end
        end
        if (dd_neg)
            acc = -acc;
        if (dd != '0 && dd_neg != dv_neg)
            quo = -quo;
        r.quo = FIELD_W'($signed(quo));
        r.rem = FIELD_W'($signed(acc));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_divisions.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (operand_valid && !operand_stall)
                pending_divisions.push_back(restoring_divide(dividend, divisor));
            if (result_valid && !result_stall)
            begin
                if (pending_divisions.size() == 0)
                begin
                    $error("result item with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_divisions.pop_front();
                    if (quotient !== want.quo)
                    begin
                        $error("quotient: expected %0d, got %0d", want.quo, quotient);
                        mismatches++;
                    end
                    if (remainder !== want.rem)
                    begin
                        $error("remainder: expected %0d, got %0d", want.rem, remainder);
                        mismatches++;
                    end
                    if (divide_by_zero !== want.dz)
                    begin
                        $error("divide_by_zero: expected %0b, got %0b", want.dz, divide_by_zero);
                        mismatches++;
                    end
                end
            end
            outstanding = pending_divisions.size();
        end
    end

endmodule

FILE: tb/tb.sv
// top of the signed restoring divider testbench: clock, reset, operand stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srd_pkg::*;

    localparam int WIDTH = 16;

    logic   clk;
    logic   rst_n;
    logic   operand_valid;
    logic   operand_stall;
    field_t dividend;
    field_t divisor;
    logic   result_valid;
    logic   result_stall;
    field_t quotient;
    field_t remainder;
    logic   divide_by_zero;
    int     mismatches;
    int     outstanding;
    logic   calm;

    signed_restoring_divider #(.WIDTH(WIDTH)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .operand_valid  (operand_valid),
        .operand_stall  (operand_stall),
        .dividend       (dividend),
        .divisor        (divisor),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero)
    );

    srd_checker #(.WIDTH(WIDTH)) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .operand_valid  (operand_valid),
        .operand_stall  (operand_stall),
        .dividend       (dividend),
        .divisor        (divisor),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(99);
        if (calm)
            return 0;
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(3, 1);
        if (pick < 97)
            return $urandom_range(8, 4);
        return $urandom_range(50, 20);
    endfunction

    function automatic field_t random_operand();
        int pick;
        int mag;
        pick = $urandom_range(19);
        if (pick < 8)
            return field_t'($urandom);
        if (pick < 14)
            return field_t'($urandom_range(600) - 300);
        if (pick < 16)
        begin
            mag = 32767 - $urandom_range(60);
            return $urandom_range(1) ? field_t'(-mag) : field_t'(mag);
        end
        if (pick < 18)
        begin
            case ($urandom_range(4))
                0: return field_t'(32767);
                1: return field_t'(-32767);
                2: return field_t'(-32768);
                3: return field_t'(1);
                default: return field_t'(-1);
            endcase
        end
        return '0;
    endfunction

    task automatic send_operands(field_t dd, field_t dv);
        int gap;
        @(negedge clk);
        operand_valid <= 1'b1;
        dividend      <= dd;
        divisor       <= dv;
        do
            @(posedge clk);
        while (operand_stall);
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            operand_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        operand_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // receiver: short and long stalls, with quiet stretches
    initial
    begin
        int hold;
        int pick;
        result_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                pick = $urandom_range(39);
                if (pick == 0)
                begin
                    result_stall <= 1'b1;
                    hold = $urandom_range(60, 20);
                end
                else if (pick < 10)
                begin
                    result_stall <= 1'b1;
                    hold = $urandom_range(2);
                end
                else if (pick < 12)
                begin
                    result_stall <= 1'b0;
                    hold = $urandom_range(200, 50);
                end
                else
                    result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        operand_valid = 1'b0;
        dividend      = '0;
        divisor       = '0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_operands(0, 1);
        send_operands(0, -1);
        send_operands(32767, 1);
        send_operands(-32767, 1);
        send_operands(32767, -32767);
        send_operands(-32767, -32767);
        send_operands(1, 32767);
        send_operands(-1, 32767);
        send_operands(5, 0);
        send_operands(-32768, 0);
        send_operands(0, 0);
        send_operands(100, 7);
        send_operands(-100, 7);
        send_operands(100, -7);
        send_operands(-100, -7);
        send_operands(7, 100);
        send_operands(-32768, 1);
        send_operands(-32768, -1);
        send_operands(1, -32768);
        send_operands(-32768, -32768);
        send_operands(32767, 2);
        send_operands(-32767, -2);
        send_operands(12345, 12345);
        send_operands(-21846, 21845);
        drain();

        for (int i = 0; i < 850; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(3) == 0);
            if (i == 425)
                drain();
            send_operands(random_operand(), random_operand());
        end

        drain();
        repeat (WIDTH + 20) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: signed_restoring_divider.f
+incdir+rtl
rtl/srd_pkg.sv
rtl/signed_restoring_divider.sv
tb/srd_checker.sv
tb/tb.sv
